FILE: src/qexp_pkg.sv
// ----------------------------------------------------------------------------
// qexp_pkg
// Shared widths, constants, coefficient tables and the pipeline word type
// for the quaternion exponential core.
// ----------------------------------------------------------------------------
package qexp_pkg;

   // number formats
   localparam int FRAC_BITS = 16;
   localparam int IN_W      = FRAC_BITS + 4;     // signed Q3.FRAC_BITS
   localparam int OUTW_W    = FRAC_BITS + 2;     // signed Q1.FRAC_BITS
   localparam int LIMIT_W   = 16;                // Q0.16 sine threshold
   localparam int Q30_SH    = 30 - FRAC_BITS;    // input scale to Q30
   localparam int LIMIT_SH  = 30 - LIMIT_W;      // threshold scale to Q30

   // internal widths
   localparam int SQ_W    = 2 * IN_W;            // one square, also sum of three
   localparam int ROOT_W  = IN_W;                // floor sqrt of the sum
   localparam int REM_W   = ROOT_W + 2;          // sqrt partial remainder
   localparam int A30_W   = ROOT_W + Q30_SH;     // angle in Q30
   localparam int RS_W    = A30_W + 2;           // signed reduced angle
   localparam int U_W     = 31;                  // |reduced angle| <= pi/2
   localparam int U2_W    = 32;                  // u squared in Q30
   localparam int T_W     = 33;                  // series term and product
   localparam int ACC_W   = 35;                  // signed series sums
   localparam int SMAG_W  = 31;                  // clamped sine, up to one
   localparam int QUO_W   = IN_W + 1;            // scaled component magnitude
   localparam int NUM_W   = IN_W + SMAG_W - 1;   // mag * sine + angle / 2
   localparam int DREM_W  = A30_W;               // divider partial remainder
   localparam int DIV_W   = 9;                   // series divisors
   localparam int TERMS   = 8;                   // series terms after the first
   localparam int RCP_SH  = 34;                  // reciprocal scale
   localparam int RCP_W   = RCP_SH + 1;

   // pipeline depths
   localparam int FRONT_ST  = 17;
   localparam int SERIES_ST = 3 * TERMS;
   localparam int BACK_ST   = 2;
   localparam int DIV_ST    = (QUO_W + 1) / 2;

   // Q30 constants
   localparam logic [U_W-1:0]           Q30_ONE      = U_W'(64'd1 << 30);
   localparam logic signed [ACC_W-1:0]  ACC_ONE      = ACC_W'(64'd1 << 30);
   localparam logic [A30_W-1:0]         RED_TWO_PI   = A30_W'(64'd6746518852);
   localparam logic [A30_W-1:0]         RED_FOUR_PI  = A30_W'(64'd13493037704);
   localparam logic signed [RS_W-1:0]   Q30_PI       = RS_W'(64'd3373259426);
   localparam logic signed [RS_W-1:0]   Q30_TWO_PI   = RS_W'(64'd6746518852);
   localparam logic signed [RS_W-1:0]   Q30_HALF_PI  = RS_W'(64'd1686629713);
   localparam logic [SMAG_W-1:0]        W_ROUND      = SMAG_W'(64'd1 << (Q30_SH - 1));

   // taylor divisors and their reciprocals
   localparam logic [63:0] RCP_ONE = 64'd1 << RCP_SH;
   localparam logic [DIV_W-1:0] SIN_DIV [TERMS] = '{
      9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
   localparam logic [DIV_W-1:0] COS_DIV [TERMS] = '{
      9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};
   localparam logic [RCP_W-1:0] SIN_RECIP [TERMS] = '{
      RCP_W'(RCP_ONE / 64'd6),   RCP_W'(RCP_ONE / 64'd20),
      RCP_W'(RCP_ONE / 64'd42),  RCP_W'(RCP_ONE / 64'd72),
      RCP_W'(RCP_ONE / 64'd110), RCP_W'(RCP_ONE / 64'd156),
      RCP_W'(RCP_ONE / 64'd210), RCP_W'(RCP_ONE / 64'd272)};
   localparam logic [RCP_W-1:0] COS_RECIP [TERMS] = '{
      RCP_W'(RCP_ONE / 64'd2),   RCP_W'(RCP_ONE / 64'd12),
      RCP_W'(RCP_ONE / 64'd30),  RCP_W'(RCP_ONE / 64'd56),
      RCP_W'(RCP_ONE / 64'd90),  RCP_W'(RCP_ONE / 64'd132),
      RCP_W'(RCP_ONE / 64'd182), RCP_W'(RCP_ONE / 64'd240)};

   // word that travels down the pipeline
   typedef struct packed {
      logic [2:0][IN_W-1:0]   vec;
      logic [2:0][IN_W-1:0]   mag;
      logic [2:0][SQ_W-1:0]   sq;
      logic [SQ_W-1:0]        rad;
      logic [REM_W-1:0]       rem;
      logic [ROOT_W-1:0]      root;
      logic [A30_W-1:0]       a30;
      logic signed [RS_W-1:0] rs;
      logic                   sneg;
      logic                   cneg;
      logic [U_W-1:0]         u;
      logic [U2_W-1:0]        u2;
      logic [T_W-1:0]         ts;
      logic [T_W-1:0]         tc;
      logic [T_W-1:0]         ps;
      logic [T_W-1:0]         pc;
      logic signed [ACC_W-1:0] s;
      logic signed [ACC_W-1:0] c;
      logic [SMAG_W-1:0]      smag;
      logic signed [OUTW_W-1:0] w;
      logic                   pass;
      logic [2:0][DREM_W-1:0] drem;
      logic [2:0][QUO_W-1:0]  nlow;
      logic [2:0][QUO_W-1:0]  quo;
   } item_type;

endpackage

FILE: src/qexp_if.sv
// ----------------------------------------------------------------------------
// qexp channel interfaces
// Valid/ready channels for the request, response and csr words.
// ----------------------------------------------------------------------------
interface qexp_req_if;
   import qexp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] vec_x;
   logic signed [IN_W-1:0] vec_y;
   logic signed [IN_W-1:0] vec_z;
   modport source (output valid, vec_x, vec_y, vec_z, input ready);
   modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface qexp_rsp_if;
   import qexp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [OUTW_W-1:0] out_w;
   logic signed [IN_W-1:0]   out_x;
   logic signed [IN_W-1:0]   out_y;
   logic signed [IN_W-1:0]   out_z;
   modport source (output valid, out_w, out_x, out_y, out_z, input ready);
   modport sink   (input valid, out_w, out_x, out_y, out_z, output ready);
endinterface

interface qexp_csr_if;
   import qexp_pkg::*;
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] tiny_sine_limit;
   modport source (output valid, tiny_sine_limit, input ready);
   modport sink   (input valid, tiny_sine_limit, output ready);
endinterface

FILE: src/qexp_series.sv
// ----------------------------------------------------------------------------
// qexp_series
// Pipelined taylor series for sine and cosine of the reduced angle, three
// stages per term: multiply by u squared, reciprocal multiply, correction.
// ----------------------------------------------------------------------------
module qexp_series
   import qexp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     out_valid,
   output item_type out_item
);

   logic [SERIES_ST-1:0] valid_ff;
   item_type             item_ff [SERIES_ST];
   item_type             item_in [SERIES_ST];

   // one phase of one term
   function automatic item_type series_step(input item_type it, input int term,
                                            input int ph);
      item_type             o;
      logic [T_W+U2_W-1:0]  mprod_s;
      logic [T_W+U2_W-1:0]  mprod_c;
      logic [T_W+RCP_W-1:0] rprod_s;
      logic [T_W+RCP_W-1:0] rprod_c;
      logic [T_W-1:0]       rem_s;
      logic [T_W-1:0]       rem_c;
      o = it;
      if (ph == 0) begin
         mprod_s = (T_W+U2_W)'(it.ts) * (T_W+U2_W)'(it.u2);
         mprod_c = (T_W+U2_W)'(it.tc) * (T_W+U2_W)'(it.u2);
         o.ps = mprod_s[30 +: T_W];
         o.pc = mprod_c[30 +: T_W];
      end else if (ph == 1) begin
         rprod_s = (T_W+RCP_W)'(it.ps) * (T_W+RCP_W)'(SIN_RECIP[term]);
         rprod_c = (T_W+RCP_W)'(it.pc) * (T_W+RCP_W)'(COS_RECIP[term]);
         o.ts = rprod_s[RCP_SH +: T_W];
         o.tc = rprod_c[RCP_SH +: T_W];
      end else begin
         // estimate is low by at most one
         rem_s = it.ps - T_W'(it.ts * T_W'(SIN_DIV[term]));
         rem_c = it.pc - T_W'(it.tc * T_W'(COS_DIV[term]));
         if (rem_s >= T_W'(SIN_DIV[term])) o.ts = it.ts + 1'b1;
         if (rem_c >= T_W'(COS_DIV[term])) o.tc = it.tc + 1'b1;
         if ((term % 2) == 0) begin
            o.s = it.s - $signed(ACC_W'(o.ts));
            o.c = it.c - $signed(ACC_W'(o.tc));
         end else begin
            o.s = it.s + $signed(ACC_W'(o.ts));
            o.c = it.c + $signed(ACC_W'(o.tc));
         end
      end
      return o;
   endfunction

   // stage logic
   for (genvar j = 0; j < SERIES_ST; j++) begin : g_stage
      localparam int TERM = j / 3;
      localparam int PH   = j % 3;
      if (j == 0) begin : g_first
         assign item_in[j] = series_step(in_item, TERM, PH);
      end else begin : g_next
         assign item_in[j] = series_step(item_ff[j-1], TERM, PH);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[SERIES_ST-2:0], in_valid};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff[SERIES_ST-1];
   assign out_item  = item_ff[SERIES_ST-1];

endmodule

FILE: src/qexp_div.sv
// ----------------------------------------------------------------------------
// qexp_div
// Pipelined restoring divider, three lanes sharing the angle as divisor,
// two quotient bits per stage.
// ----------------------------------------------------------------------------
module qexp_div
   import qexp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     out_valid,
   output item_type out_item
);

   logic [DIV_ST-1:0] valid_ff;
   item_type          item_ff [DIV_ST];
   item_type          item_in [DIV_ST];

   // quotient bits first to first + 1 for all lanes
   function automatic item_type div_step(input item_type it, input int first);
      item_type          o;
      logic [DREM_W:0]   trial;
      o = it;
      for (int k = 0; k < 2; k++) begin
         if (first + k < QUO_W) begin
            for (int i = 0; i < 3; i++) begin
               trial = {o.drem[i], o.nlow[i][QUO_W-1]};
               o.nlow[i] = o.nlow[i] << 1;
               if (trial >= {1'b0, o.a30}) begin
                  o.drem[i] = DREM_W'(trial - {1'b0, o.a30});
                  o.quo[i]  = {o.quo[i][QUO_W-2:0], 1'b1};
               end else begin
                  o.drem[i] = DREM_W'(trial);
                  o.quo[i]  = {o.quo[i][QUO_W-2:0], 1'b0};
               end
            end
         end
      end
      return o;
   endfunction

   // stage logic
   for (genvar j = 0; j < DIV_ST; j++) begin : g_stage
      if (j == 0) begin : g_first
         assign item_in[j] = div_step(in_item, 2 * j);
      end else begin : g_next
         assign item_in[j] = div_step(item_ff[j-1], 2 * j);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_ST-2:0], in_valid};
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff[DIV_ST-1];
   assign out_item  = item_ff[DIV_ST-1];

endmodule

FILE: src/quaternion_exp_core.sv
// ----------------------------------------------------------------------------
// quaternion_exp_core
// Exponential of a pure quaternion: w = cos(|v|), v scaled by sin(|v|)/|v|.
// ----------------------------------------------------------------------------
// usage
//   req: one word per vector, vec_x/vec_y/vec_z in signed Q3.16.
//   rsp: one word per request in order, out_w in Q1.16, out_x/y/z in Q3.16
//        saturating; the vector passes unchanged when the angle is zero or
//        the sine magnitude is under the threshold.
//   csr: writes tiny_sine_limit (Q0.16), always ready; write only while idle.
//   pipeline: 17 front stages for squares, square root and range reduction,
//        24 series stages, 2 stages for clamp and numerator, 11 divider
//        stages, 1 output register.
//   throughput: one word per cycle unless stalled, every stage a register stage.
//   stall: when rsp holds a word that is not taken the whole pipeline holds
//        and req.ready drops in the same cycle; nothing is lost or repeated.
//   reset: clears all valid bits and loads the threshold with 1.
// ----------------------------------------------------------------------------
module quaternion_exp_core
   import qexp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   qexp_req_if.sink   req_port,
   qexp_rsp_if.source rsp_port,
   qexp_csr_if.sink   csr_port
);

   logic [LIMIT_W-1:0] limit_ff;
   logic               pipe_en;

   logic [FRONT_ST-1:0] front_valid_ff;
   item_type            front_ff [FRONT_ST];
   item_type            front_in [FRONT_ST];
   logic [BACK_ST-1:0]  back_valid_ff;
   item_type            back_ff [BACK_ST];
   item_type            back_in [BACK_ST];
   logic                series_valid;
   item_type            series_item;
   logic                div_valid;
   item_type            div_item;

   logic                     out_valid_ff;
   logic signed [OUTW_W-1:0] out_w_ff;
   logic [2:0][IN_W-1:0]     out_vec_ff;
   logic [2:0][IN_W-1:0]     out_vec_in;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_W'(1);
      end else if (csr_port.valid) begin
         limit_ff <= csr_port.tiny_sine_limit;
      end
   end
   assign csr_port.ready = 1'b1;

   // whole pipeline advances unless the output word is held
   assign pipe_en        = !out_valid_ff || rsp_port.ready;
   assign req_port.ready = pipe_en;

   // front: squares, square root, range reduction
   function automatic item_type front_step(input item_type it, input int k);
      item_type              o;
      logic [REM_W+1:0]      trial;
      logic [REM_W-1:0]      tq;
      logic [A30_W-1:0]      a30;
      logic [A30_W-1:0]      red;
      logic [2*U_W-1:0]      usq;
      o = it;
      if (k == 1) begin
         for (int i = 0; i < 3; i++) begin
            o.sq[i] = SQ_W'(it.mag[i]) * SQ_W'(it.mag[i]);
         end
      end else if (k == 2) begin
         o.rad  = it.sq[0] + it.sq[1] + it.sq[2];
         o.rem  = '0;
         o.root = '0;
      end else if (k <= 12) begin
         // two root bits per stage
         for (int j = 0; j < 2; j++) begin
            trial = {o.rem, o.rad[SQ_W-1 -: 2]};
            tq    = {o.root, 2'b01};
            o.rad = o.rad << 2;
            if (trial >= {2'b00, tq}) begin
               o.rem  = REM_W'(trial - {2'b00, tq});
               o.root = {o.root[ROOT_W-2:0], 1'b1};
            end else begin
               o.rem  = REM_W'(trial);
               o.root = {o.root[ROOT_W-2:0], 1'b0};
            end
         end
      end else if (k == 13) begin
         a30   = {it.root, {Q30_SH{1'b0}}};
         o.a30 = a30;
         if (a30 >= RED_FOUR_PI) begin
            red = a30 - RED_FOUR_PI;
         end else if (a30 >= RED_TWO_PI) begin
            red = a30 - RED_TWO_PI;
         end else begin
            red = a30;
         end
         o.rs = $signed(RS_W'(red));
      end else if (k == 14) begin
         if (it.rs > Q30_PI) o.rs = it.rs - Q30_TWO_PI;
      end else if (k == 15) begin
         // fold into [-pi/2, pi/2]
         if (it.rs > Q30_HALF_PI) begin
            o.rs   = Q30_PI - it.rs;
            o.cneg = 1'b1;
         end else if (it.rs < -Q30_HALF_PI) begin
            o.rs   = -Q30_PI - it.rs;
            o.cneg = 1'b1;
         end else begin
            o.cneg = 1'b0;
         end
         o.sneg = o.rs[RS_W-1];
         o.u    = o.sneg ? U_W'(-o.rs) : U_W'(o.rs);
      end else begin
         usq  = (2*U_W)'(it.u) * (2*U_W)'(it.u);
         o.u2 = usq[30 +: U2_W];
         o.ts = T_W'(it.u);
         o.tc = T_W'(Q30_ONE);
         o.s  = $signed(ACC_W'(it.u));
         o.c  = ACC_ONE;
      end
      return o;
   endfunction

   // request capture and magnitudes
   always_comb begin
      front_in[0]        = '0;
      front_in[0].vec[0] = req_port.vec_x;
      front_in[0].vec[1] = req_port.vec_y;
      front_in[0].vec[2] = req_port.vec_z;
      for (int i = 0; i < 3; i++) begin
         front_in[0].mag[i] = front_in[0].vec[i][IN_W-1] ?
                              (~front_in[0].vec[i] + 1'b1) : front_in[0].vec[i];
      end
   end

   for (genvar k = 1; k < FRONT_ST; k++) begin : g_front
      assign front_in[k] = front_step(front_ff[k-1], k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
      end else if (pipe_en) begin
         front_valid_ff <= {front_valid_ff[FRONT_ST-2:0], req_port.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         front_ff <= front_in;
      end
   end

   // sine and cosine series
   qexp_series u_series (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (front_valid_ff[FRONT_ST-1]),
      .in_item   (front_ff[FRONT_ST-1]),
      .out_valid (series_valid),
      .out_item  (series_item)
   );

   // back: clamp, cosine output, bypass test, divider numerators
   function automatic item_type back_step(input item_type it, input int k,
                                          input logic [LIMIT_W-1:0] limit);
      item_type              o;
      logic [SMAG_W-1:0]     s_cl;
      logic [SMAG_W-1:0]     c_cl;
      logic [SMAG_W-1:0]     c_rnd;
      logic [NUM_W-1:0]      num;
      o = it;
      if (k == 0) begin
         if (it.s < 0)            s_cl = '0;
         else if (it.s > ACC_ONE) s_cl = SMAG_W'(Q30_ONE);
         else                     s_cl = SMAG_W'(it.s);
         if (it.c < 0)            c_cl = '0;
         else if (it.c > ACC_ONE) c_cl = SMAG_W'(Q30_ONE);
         else                     c_cl = SMAG_W'(it.c);
         c_rnd  = c_cl + W_ROUND;
         o.w    = it.cneg ? -$signed(OUTW_W'(c_rnd >> Q30_SH))
                          :  $signed(OUTW_W'(c_rnd >> Q30_SH));
         o.smag = s_cl;
         o.pass = (it.a30 == '0) ||
                  (s_cl < SMAG_W'({limit, {LIMIT_SH{1'b0}}}));
      end else begin
         for (int i = 0; i < 3; i++) begin
            num = NUM_W'(it.mag[i]) * NUM_W'(it.smag) + NUM_W'(it.a30 >> 1);
            o.drem[i] = DREM_W'(num >> QUO_W);
            o.nlow[i] = num[QUO_W-1:0];
            o.quo[i]  = '0;
         end
      end
      return o;
   endfunction

   assign back_in[0] = back_step(series_item, 0, limit_ff);
   assign back_in[1] = back_step(back_ff[0], 1, limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         back_valid_ff <= '0;
      end else if (pipe_en) begin
         back_valid_ff <= {back_valid_ff[BACK_ST-2:0], series_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         back_ff <= back_in;
      end
   end

   // component scaling divider
   qexp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (back_valid_ff[BACK_ST-1]),
      .in_item   (back_ff[BACK_ST-1]),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   // sign, saturation and bypass select
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (div_item.pass) begin
            out_vec_in[i] = div_item.vec[i];
         end else if (div_item.vec[i][IN_W-1] == div_item.sneg) begin
            if (div_item.quo[i] > QUO_W'((64'd1 << (IN_W-1)) - 64'd1))
               out_vec_in[i] = {1'b0, {(IN_W-1){1'b1}}};
            else
               out_vec_in[i] = IN_W'(div_item.quo[i]);
         end else begin
            if (div_item.quo[i] > QUO_W'(64'd1 << (IN_W-1)))
               out_vec_in[i] = {1'b1, {(IN_W-1){1'b0}}};
            else
               out_vec_in[i] = -IN_W'(div_item.quo[i]);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_w_ff   <= div_item.w;
         out_vec_ff <= out_vec_in;
      end
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.out_w = out_w_ff;
   assign rsp_port.out_x = out_vec_ff[0];
   assign rsp_port.out_y = out_vec_ff[1];
   assign rsp_port.out_z = out_vec_ff[2];

   // checks
   a_reset_clears_out: assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("response valid after reset");

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_w_ff <= OUTW_W'(65536)) && (out_w_ff >= -OUTW_W'(65536)))
      else $error("cosine out of range");

   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      div_valid && !div_item.pass |->
         (div_item.quo[0] <= QUO_W'(64'd1 << (IN_W-1))) &&
         (div_item.quo[1] <= QUO_W'(64'd1 << (IN_W-1))) &&
         (div_item.quo[2] <= QUO_W'(64'd1 << (IN_W-1))))
      else $error("scaled component exceeds input range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(front_valid_ff) && $stable(back_valid_ff))
      else $error("pipeline moved during stall");

endmodule
